// File: rtl/flow_affinity_load_balancer_macros.svh
// Assertion macros for the flow affinity load balancer.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef FLOW_AFFINITY_LOAD_BALANCER_MACROS_SVH
`define FLOW_AFFINITY_LOAD_BALANCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FAL_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fal assertion failed");

// Next-cycle implication, disabled during reset.
`define FAL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fal assertion failed");

`endif

// File: rtl/fal_pkg.sv
`timescale 1ns / 1ps
// Package for the flow affinity load balancer: widths, protocol codes,
// the search token passed along the cell row, controller states.
package fal_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int MAX_BACKENDS_DEF  = 10;

   localparam int ETYPE_W = 16;
   localparam int ADDR_W  = 32;
   localparam int PROTO_W = 8;
   localparam int PORT_W  = 16;
   localparam int CNT_W   = 4;
   localparam int BE_W    = 4;
   localparam int AKEY_W  = 2 * ADDR_W;
   localparam int PKEY_W  = PROTO_W + 2 * PORT_W;
   localparam int NUM_W   = BE_W + 1;

   localparam logic [ETYPE_W-1:0] ETHER_TYPE_IPV4   = 16'h0800;
   localparam logic [PROTO_W-1:0] PROTO_TCP         = 8'd6;
   localparam logic [PROTO_W-1:0] PROTO_UDP         = 8'd17;
   localparam logic [CNT_W-1:0]   BACKEND_COUNT_RST = 4'd10;

   // Search token: key plus what the row has found so far.
   typedef struct packed {
      logic [AKEY_W-1:0] akey;
      logic [PKEY_W-1:0] pkey;
      logic [BE_W-1:0]   backend;  // selected backend, replaced on a hit
      logic              hit;
      logic              placed;   // key was written into a free cell
   } tok_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } fal_state_type;

   // Backend b lives at (b+1).0.0.0
   function automatic logic [ADDR_W-1:0] backend_addr(input logic [BE_W-1:0] b);
      logic [NUM_W-1:0] b1;
      b1 = {1'b0, b} + NUM_W'(1);
      backend_addr = {3'd0, b1, 24'd0};
   endfunction

endpackage

// File: rtl/fal_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready plus payload).
// Depends on fal_pkg.
interface fal_req_if;
   import fal_pkg::*;
   logic               valid;
   logic               ready;
   logic [ETYPE_W-1:0] eth_type;
   logic [ADDR_W-1:0]  saddr;
   logic [ADDR_W-1:0]  daddr;
   logic [PROTO_W-1:0] protocol;
   logic [PORT_W-1:0]  sport;
   logic [PORT_W-1:0]  dport;

   modport source (output valid, eth_type, saddr, daddr, protocol,
                   sport, dport, input ready);
   modport sink   (input valid, eth_type, saddr, daddr, protocol,
                   sport, dport, output ready);
endinterface

interface fal_rsp_if;
   import fal_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] new_dst_addr;
   logic              rewritten;
   logic              flow_hit;
   logic              table_full;

   modport source (output valid, new_dst_addr, rewritten, flow_hit, table_full,
                   input ready);
   modport sink   (input valid, new_dst_addr, rewritten, flow_hit, table_full,
                   output ready);
endinterface

// File: rtl/fal_cell.sv
`timescale 1ns / 1ps
// One flow table entry plus one stage of the search token pipeline.
// Depends on fal_pkg.
module fal_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   input  fal_pkg::tok_type in_tok,
   output logic             out_vld,
   output fal_pkg::tok_type out_tok
);
   import fal_pkg::*;

   logic              valid_ff, valid_in;
   logic [AKEY_W-1:0] akey_ff;
   logic [PKEY_W-1:0] pkey_ff;
   logic [BE_W-1:0]   backend_ff;
   logic              vld_ff;
   tok_type           tok_ff, tok_in;
   logic              match, ins;

   always_comb begin
      match = valid_ff && (akey_ff == in_tok.akey) && (pkey_ff == in_tok.pkey);
      // entries fill in order, so the first empty cell ends any chance of a hit
      ins   = in_vld && !in_tok.hit && !in_tok.placed && !valid_ff;
      tok_in = in_tok;
      if (in_vld && match && !in_tok.hit) begin
         tok_in.hit     = 1'b1;
         tok_in.backend = backend_ff;
      end
      if (ins) begin
         tok_in.placed = 1'b1;
      end
      valid_in = valid_ff | ins;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         vld_ff   <= in_vld;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      if (ins) begin
         akey_ff    <= in_tok.akey;
         pkey_ff    <= in_tok.pkey;
         backend_ff <= in_tok.backend;
      end
   end

   assign out_vld = vld_ff;
   assign out_tok = tok_ff;

endmodule

// File: rtl/flow_affinity_load_balancer.sv
`timescale 1ns / 1ps
// Flow affinity load balancer top level: controller, round robin and cell row.
// Depends on fal_pkg, fal_if, fal_cell and the macros header.
//
// Usage:
//  - req_if (sink): one parsed packet header per request. rsp_if (source): one
//    response per request, in order. csr_we/csr_wdata set backend_count.
//  - Non-IPv4 requests pass through with the destination address unchanged.
//  - IPv4 requests send a search token down a row of TABLE_ENTRIES cells, one
//    cell per cycle; each cell holds one flow entry. The token picks up a hit
//    or claims the first free cell on its way.
//  - One request is in flight at a time; a new one is accepted once the
//    previous result sits in the output register, so for IPv4 requests the
//    spacing between accepts is set by the length of the cell row.
//  - Reset clears all entry valid bits at once, the round-robin pointer, and
//    sets backend_count to 10; no clearing pass is needed.
//  - If the receiver stalls, the result waits in the output register; the
//    next request is still accepted, but its result waits with req_if.ready low.
module flow_affinity_load_balancer #(
   parameter int TABLE_ENTRIES = fal_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_BACKENDS  = fal_pkg::MAX_BACKENDS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   fal_req_if.sink                   req_if,
   fal_rsp_if.source                 rsp_if,
   input  logic                      csr_we,
   input  logic [fal_pkg::CNT_W-1:0] csr_wdata
);
   import fal_pkg::*;

   // control
   fal_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  bcount_ff;
   logic [BE_W-1:0]   next_be_ff, next_be_in;
   logic              accept, is_ipv4, is_l4, load_rsp;

   // pending result, filled at accept (pass-through) or at end of row
   logic [ADDR_W-1:0] res_addr_ff;
   logic              res_rw_ff, res_hit_ff, res_full_ff;

   // output register
   logic              rsp_vld_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic              rsp_rw_ff, rsp_hit_ff, rsp_full_ff;

   // round robin
   logic [NUM_W-1:0]  eff_n;
   logic [BE_W-1:0]   sel;
   logic [NUM_W-1:0]  end_sel_p1;

   // cell row
   logic                     launch_vld;
   tok_type                  launch_tok;
   logic [TABLE_ENTRIES-1:0] vld_row;
   tok_type                  tok_row [TABLE_ENTRIES];
   logic                     end_vld;
   tok_type                  end_tok;

   assign accept  = req_if.valid && req_if.ready;
   assign is_ipv4 = (req_if.eth_type == ETHER_TYPE_IPV4);
   assign is_l4   = req_if.protocol inside {PROTO_TCP, PROTO_UDP};
   assign end_vld = vld_row[TABLE_ENTRIES-1];
   assign end_tok = tok_row[TABLE_ENTRIES-1];

   // Effective backend count: 0 acts as 1, clamp at MAX_BACKENDS.
   always_comb begin
      if (bcount_ff == '0) begin
         eff_n = NUM_W'(1);
      end else if ({1'b0, bcount_ff} > NUM_W'(MAX_BACKENDS)) begin
         eff_n = NUM_W'(MAX_BACKENDS);
      end else begin
         eff_n = {1'b0, bcount_ff};
      end
      // stale pointer (count lowered) falls back to backend 0
      sel = ({1'b0, next_be_ff} < eff_n) ? next_be_ff : '0;
      end_sel_p1 = {1'b0, end_tok.backend} + NUM_W'(1);
      next_be_in = next_be_ff;
      // advance only on a miss; the token still carries the selected index
      if (end_vld && !end_tok.hit) begin
         next_be_in = (end_sel_p1 >= eff_n) ? '0 : end_sel_p1[BE_W-1:0];
      end
   end

   // Token launched into cell 0 at accept.
   always_comb begin
      launch_vld         = accept && is_ipv4;
      launch_tok.akey    = {req_if.saddr, req_if.daddr};
      launch_tok.pkey    = {req_if.protocol,
                            is_l4 ? req_if.sport : PORT_W'(0),
                            is_l4 ? req_if.dport : PORT_W'(0)};
      launch_tok.backend = sel;
      launch_tok.hit     = 1'b0;
      launch_tok.placed  = 1'b0;
   end

   // Row of flow cells, token moves one cell per cycle.
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_head
         fal_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .in_vld  (launch_vld),
            .in_tok  (launch_tok),
            .out_vld (vld_row[i]),
            .out_tok (tok_row[i])
         );
      end else begin : g_body
         fal_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .in_vld  (vld_row[i-1]),
            .in_tok  (tok_row[i-1]),
            .out_vld (vld_row[i]),
            .out_tok (tok_row[i])
         );
      end
   end

   // Controller next state.
   always_comb begin
      state_in     = state_ff;
      req_if.ready = 1'b0;
      load_rsp     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               state_in = is_ipv4 ? ST_SEARCH : ST_DONE;
            end
         end
         ST_SEARCH: begin
            if (end_vld) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // stage into output register once it is free or draining
            if (!rsp_vld_ff || rsp_if.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bcount_ff  <= BACKEND_COUNT_RST;
         next_be_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         next_be_ff <= next_be_in;
         if (csr_we) begin
            bcount_ff <= csr_wdata;
         end
         if (load_rsp) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (accept && !is_ipv4) begin
         res_addr_ff <= req_if.daddr;
         res_rw_ff   <= 1'b0;
         res_hit_ff  <= 1'b0;
         res_full_ff <= 1'b0;
      end else if (end_vld) begin
         res_addr_ff <= backend_addr(end_tok.backend);
         res_rw_ff   <= 1'b1;
         res_hit_ff  <= end_tok.hit;
         res_full_ff <= !end_tok.hit && !end_tok.placed;
      end
      if (load_rsp) begin
         rsp_addr_ff <= res_addr_ff;
         rsp_rw_ff   <= res_rw_ff;
         rsp_hit_ff  <= res_hit_ff;
         rsp_full_ff <= res_full_ff;
      end
   end

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.new_dst_addr = rsp_addr_ff;
   assign rsp_if.rewritten    = rsp_rw_ff;
   assign rsp_if.flow_hit     = rsp_hit_ff;
   assign rsp_if.table_full   = rsp_full_ff;

`include "flow_affinity_load_balancer_macros.svh"

   // at most one search token in the row
   `FAL_ASSERT_SAME(a_one_token, 1'b1, $countones(vld_row) <= 1)
   // the token only leaves the row while a search is pending
   `FAL_ASSERT_SAME(a_end_in_search, end_vld, state_ff == ST_SEARCH)
   // a token cannot both hit and claim a cell
   `FAL_ASSERT_SAME(a_hit_xor_place, end_vld, !(end_tok.hit && end_tok.placed))
   // after a search the controller always has a result to stage
   `FAL_ASSERT_NEXT(a_search_done, end_vld, state_ff == ST_DONE)

endmodule
